// ----- sv/rpoa_pkg.sv -----
`timescale 1ns / 1ps

package rpoa_pkg;

	// sensor count and index width
	localparam int unsigned NUM_SENSORS = 3;
	localparam int unsigned IDX_W       = 2;

	// apb address and data widths
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned MASK_W  = 3;

	// sensor indexes
	localparam logic [IDX_W-1:0] SENSOR_RIGHT = 2'd0;
	localparam logic [IDX_W-1:0] SENSOR_LEFT  = 2'd1;
	localparam logic [IDX_W-1:0] SENSOR_DEPTH = 2'd2;

	// register indexes (word address)
	typedef enum logic [2:0] {
		REG_THR_RIGHT  = 3'd0,
		REG_THR_LEFT   = 3'd1,
		REG_THR_DEPTH  = 3'd2,
		REG_DETECT_EN  = 3'd3,
		REG_BELOW      = 3'd4,
		REG_DEPTH_EN   = 3'd5
	} reg_idx_t;

	// reset values
	localparam logic [MASK_W-1:0] BELOW_RESET = 3'd3;

	// configuration as seen by the poll logic
	typedef struct packed {
		logic [NUM_SENSORS-1:0][DIST_W-1:0] thr;
		logic [MASK_W-1:0]                  det_en;
		logic [MASK_W-1:0]                  below;
		logic                               depth_en;
	} cfg_t;

endpackage

// ----- sv/rpoa_regs.sv -----
`timescale 1ns / 1ps

module rpoa_regs
	import rpoa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	reg_idx_t   idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr      <= '0;
			cfg_q.det_en   <= '0;
			cfg_q.below    <= BELOW_RESET;
			cfg_q.depth_en <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_THR_RIGHT: cfg_q.thr[SENSOR_RIGHT] <= pwdata[DIST_W-1:0];
				REG_THR_LEFT:  cfg_q.thr[SENSOR_LEFT]  <= pwdata[DIST_W-1:0];
				REG_THR_DEPTH: cfg_q.thr[SENSOR_DEPTH] <= pwdata[DIST_W-1:0];
				REG_DETECT_EN: cfg_q.det_en   <= pwdata[MASK_W-1:0];
				REG_BELOW:     cfg_q.below    <= pwdata[MASK_W-1:0];
				REG_DEPTH_EN:  cfg_q.depth_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_THR_RIGHT: prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_q.thr[SENSOR_RIGHT]};
			REG_THR_LEFT:  prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_q.thr[SENSOR_LEFT]};
			REG_THR_DEPTH: prdata = {{(DATA_W-DIST_W){1'b0}}, cfg_q.thr[SENSOR_DEPTH]};
			REG_DETECT_EN: prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_q.det_en};
			REG_BELOW:     prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_q.below};
			REG_DEPTH_EN:  prdata = {{(DATA_W-1){1'b0}}, cfg_q.depth_en};
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- sv/rangefinder_poll_obstacle_alarm_top.sv -----
`timescale 1ns / 1ps
// an input transaction reaches the result through the input register, then the result register
// one poll tick per cycle unless the output stalls; the due-time compare and update is one pass
// the result register and the input register let a new tick enter while a result waits
// reset (arst_n, asynchronous, active low) sets due times to interval plus index times spacing,
// turn to the right sensor, alarms and stop latch clear, registers to their documented values

module rangefinder_poll_obstacle_alarm_top
	import rpoa_pkg::*;
#(
	parameter logic [31:0] INTERVAL_US = 32'd40000,
	parameter logic [31:0] SPACING_US  = 32'd5000
) (
	input  logic              clk,
	input  logic              arst_n,
	// apb
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] now_us,
	input  logic [DIST_W-1:0] reading_mm,
	input  logic              timed_out,
	// output channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              served,
	output logic [IDX_W-1:0]  served_index,
	output logic              reading_valid,
	output logic              alarm_any,
	output logic              stop_request,
	output logic [IDX_W-1:0]  next_index
);

	cfg_t cfg;

	// register file
	rpoa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input stage
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [DIST_W-1:0] reading_s1;
	logic              timed_out_s1;

	// poll state (stored distances have no visible effect and are not kept)
	logic [NUM_SENSORS-1:0][TIME_W-1:0] due_q;
	logic [IDX_W-1:0]                   turn_q;
	logic [MASK_W-1:0]                  alarm_q;
	logic                               stop_latched_q;

	// result register
	logic             out_valid_q;
	logic             served_q;
	logic [IDX_W-1:0] served_index_q;
	logic             reading_valid_q;
	logic             alarm_any_q;
	logic             stop_request_q;
	logic [IDX_W-1:0] next_index_q;

	logic advance;
	logic fire;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// poll logic for the tick in the input stage
	logic [IDX_W-1:0]                   cur;
	logic [IDX_W-1:0]                   nx;
	logic                               is_due;
	logic                               valid_rd;
	logic                               hit;
	logic [DIST_W-1:0]                  thr_cur;
	logic [TIME_W-1:0]                  resched;
	logic [TIME_W-1:0]                  floor_t;
	logic [NUM_SENSORS-1:0][TIME_W-1:0] due_nxt;
	logic [MASK_W-1:0]                  alarm_nxt;
	logic [IDX_W-1:0]                   turn_nxt;
	logic                               any_nxt;
	logic                               stop_nxt;

	always_comb begin
		cur      = (turn_q > SENSOR_DEPTH) ? SENSOR_RIGHT : turn_q;
		is_due   = due_q[cur] < now_s1;
		valid_rd = is_due && !timed_out_s1;
		thr_cur  = cfg.thr[cur];
		if (cfg.below[cur]) begin
			hit = thr_cur > reading_s1;
		end else begin
			hit = thr_cur < reading_s1;
		end
		resched = now_s1 + INTERVAL_US;
		floor_t = now_s1 + SPACING_US;

		// next sensor in rotation
		if (cur == SENSOR_DEPTH) begin
			nx = SENSOR_RIGHT;
		end else begin
			nx = cur + 2'd1;
		end
		if (!cfg.depth_en && nx == SENSOR_DEPTH) begin
			nx = SENSOR_RIGHT;
		end

		due_nxt   = due_q;
		alarm_nxt = alarm_q;
		turn_nxt  = turn_q;
		if (is_due) begin
			due_nxt[cur] = resched;
			if (due_nxt[nx] < floor_t) begin
				due_nxt[nx] = floor_t;
			end
			turn_nxt = nx;
			if (valid_rd && cfg.det_en[cur] && hit) begin
				alarm_nxt[cur] = 1'b1;
			end
		end

		any_nxt  = (cfg.det_en & alarm_nxt) != '0;
		stop_nxt = valid_rd && !stop_latched_q && any_nxt;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1       <= now_us;
			reading_s1   <= reading_mm;
			timed_out_s1 <= timed_out;
		end
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				due_q[i] <= INTERVAL_US + TIME_W'(i) * SPACING_US;
			end
			turn_q         <= SENSOR_RIGHT;
			alarm_q        <= '0;
			stop_latched_q <= 1'b0;
		end else if (fire) begin
			due_q   <= due_nxt;
			turn_q  <= turn_nxt;
			alarm_q <= alarm_nxt;
			if (stop_nxt) begin
				stop_latched_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			served_q        <= is_due;
			served_index_q  <= is_due ? cur : SENSOR_RIGHT;
			reading_valid_q <= valid_rd;
			alarm_any_q     <= any_nxt;
			stop_request_q  <= stop_nxt;
			next_index_q    <= turn_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign served        = served_q;
	assign served_index  = served_index_q;
	assign reading_valid = reading_valid_q;
	assign alarm_any     = alarm_any_q;
	assign stop_request  = stop_request_q;
	assign next_index    = next_index_q;

	// stop pulse only with a valid reading and a held alarm
	a_stop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_request_q |-> reading_valid_q && alarm_any_q)
		else $error("stop request without valid reading and alarm");

	// a valid reading implies the sensor was served
	a_valid_served: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reading_valid_q |-> served_q)
		else $error("reading valid without service");

	// stop latch never clears outside reset
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stop_latched_q |=> stop_latched_q)
		else $error("stop latch cleared");

	// at most one stop pulse is ever issued
	a_stop_once: assert property (@(posedge clk) disable iff (!arst_n)
		fire && stop_nxt |-> !stop_latched_q)
		else $error("second stop request");

	// turn stays on a real sensor
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		turn_q != 2'd3)
		else $error("turn out of range");

endmodule

// ----- tb/tb_rangefinder_poll_obstacle_alarm_top.sv -----
`timescale 1ns / 1ps

module tb_rangefinder_poll_obstacle_alarm_top;
	import rpoa_pkg::*;

	localparam logic [TIME_W-1:0] INTERVAL    = 32'd40000;
	localparam logic [TIME_W-1:0] SPACING     = 32'd5000;
	localparam int unsigned       CYCLE_LIMIT = 400000;
	localparam int unsigned       TAIL_CYCLES = 8;
	localparam int unsigned       REG_SPARE_A = 6;
	localparam int unsigned       REG_SPARE_B = 7;
	localparam int unsigned       PRINT_LIMIT = 60;

	typedef struct packed {
		logic             served;
		logic [IDX_W-1:0] served_index;
		logic             reading_valid;
		logic             alarm_any;
		logic             stop_request;
		logic [IDX_W-1:0] next_index;
	} poll_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              psel       = 1'b0;
	logic              penable    = 1'b0;
	logic              pwrite     = 1'b0;
	logic [ADDR_W-1:0] paddr      = '0;
	logic [DATA_W-1:0] pwdata     = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [TIME_W-1:0] now_us     = '0;
	logic [DIST_W-1:0] reading_mm = '0;
	logic              timed_out  = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic              served;
	logic [IDX_W-1:0]  served_index;
	logic              reading_valid;
	logic              alarm_any;
	logic              stop_request;
	logic [IDX_W-1:0]  next_index;

	// predictor state and its copy of the registers
	logic [TIME_W-1:0] sensor_due [NUM_SENSORS];
	logic [IDX_W-1:0]  rr_turn;
	logic [MASK_W-1:0] alarm_latch;
	logic              stop_seen;
	logic [DIST_W-1:0] thr_mm [NUM_SENSORS];
	logic [MASK_W-1:0] detect_en;
	logic [MASK_W-1:0] below_sel;
	logic              depth_on;

	poll_result_t      poll_expect_q [$];
	int unsigned       reg_idx_q [$];
	logic [DATA_W-1:0] reg_val_q [$];

	logic [TIME_W-1:0] clock_us     = '0;
	int unsigned       sent_count   = 0;
	int unsigned       result_no    = 0;
	int unsigned       mismatches   = 0;
	int unsigned       cycle_count  = 0;
	int unsigned       hold_left    = 0;
	logic              in_gaps      = 1'b1;
	logic              out_gaps     = 1'b1;

	rangefinder_poll_obstacle_alarm_top #(
		.INTERVAL_US(INTERVAL),
		.SPACING_US (SPACING)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.now_us       (now_us),
		.reading_mm   (reading_mm),
		.timed_out    (timed_out),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.served       (served),
		.served_index (served_index),
		.reading_valid(reading_valid),
		.alarm_any    (alarm_any),
		.stop_request (stop_request),
		.next_index   (next_index)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[rangefinder_poll_obstacle_alarm_top] ERROR");
			$finish;
		end
	end

	// receiver: random idling, or a long hold-off when asked for
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(out_gaps && $urandom_range(99) < 25);
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("result %0d: %s got %0h expected %0h", result_no, what, got, want);
		mismatches++;
	endtask

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		poll_result_t want;
		if (arst_n && out_valid && out_ready) begin
			result_no++;
			if (poll_expect_q.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = poll_expect_q.pop_front();
				if (served !== want.served)
					report_mismatch("served", served, want.served);
				if (served_index !== want.served_index)
					report_mismatch("served_index", served_index, want.served_index);
				if (reading_valid !== want.reading_valid)
					report_mismatch("reading_valid", reading_valid, want.reading_valid);
				if (alarm_any !== want.alarm_any)
					report_mismatch("alarm_any", alarm_any, want.alarm_any);
				if (stop_request !== want.stop_request)
					report_mismatch("stop_request", stop_request, want.stop_request);
				if (next_index !== want.next_index)
					report_mismatch("next_index", next_index, want.next_index);
			end
		end
	end

	task automatic predictor_reset();
		for (int i = 0; i < NUM_SENSORS; i++) begin
			sensor_due[i] = INTERVAL + i * SPACING;
			thr_mm[i]     = '0;
		end
		rr_turn     = SENSOR_RIGHT;
		alarm_latch = '0;
		stop_seen   = 1'b0;
		detect_en   = '0;
		below_sel   = BELOW_RESET;
		depth_on    = 1'b1;
	endtask

	function automatic void cfg_apply(input int unsigned idx, input logic [DATA_W-1:0] val);
		case (idx)
			REG_THR_RIGHT: thr_mm[SENSOR_RIGHT] = val[DIST_W-1:0];
			REG_THR_LEFT:  thr_mm[SENSOR_LEFT]  = val[DIST_W-1:0];
			REG_THR_DEPTH: thr_mm[SENSOR_DEPTH] = val[DIST_W-1:0];
			REG_DETECT_EN: detect_en            = val[MASK_W-1:0];
			REG_BELOW:     below_sel            = val[MASK_W-1:0];
			REG_DEPTH_EN:  depth_on             = val[0];
			default: ;
		endcase
	endfunction

	// one poll tick: serve the sensor in turn if due, update alarms and the stop latch
	function automatic poll_result_t poll_tick_predict(input logic [TIME_W-1:0] t,
			input logic [DIST_W-1:0] rd, input logic to);
		poll_result_t      res;
		logic [IDX_W-1:0]  cur;
		logic [IDX_W-1:0]  nx;
		logic [TIME_W-1:0] floor_t;
		logic              hit;
		res = '0;
		cur = (rr_turn > SENSOR_DEPTH) ? SENSOR_RIGHT : rr_turn;
		if (sensor_due[cur] < t) begin
			res.served       = 1'b1;
			res.served_index = cur;
			if (!to) begin
				res.reading_valid = 1'b1;
				if (detect_en[cur]) begin
					hit = below_sel[cur] ? (rd < thr_mm[cur]) : (rd > thr_mm[cur]);
					if (hit)
						alarm_latch[cur] = 1'b1;
				end
			end
			sensor_due[cur] = t + INTERVAL;
			nx = (cur == SENSOR_DEPTH) ? SENSOR_RIGHT : cur + 2'd1;
			if (!depth_on && nx == SENSOR_DEPTH)
				nx = SENSOR_RIGHT;
			rr_turn = nx;
			floor_t = t + SPACING;
			if (sensor_due[nx] < floor_t)
				sensor_due[nx] = floor_t;
		end
		res.alarm_any = |(detect_en & alarm_latch);
		if (res.reading_valid && !stop_seen && res.alarm_any) begin
			stop_seen        = 1'b1;
			res.stop_request = 1'b1;
		end
		res.next_index = rr_turn;
		return res;
	endfunction

	// offer one tick transaction, hold it until accepted, then record the prediction
	task automatic send_tick(input logic [TIME_W-1:0] t, input logic [DIST_W-1:0] rd,
			input logic to);
		poll_result_t want;
		while (in_gaps && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		now_us     <= t;
		reading_mm <= rd;
		timed_out  <= to;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = poll_tick_predict(t, rd, to);
		poll_expect_q.push_back(want);
		sent_count++;
	endtask

	task automatic poll_later(input logic [TIME_W-1:0] step, input logic [DIST_W-1:0] rd,
			input logic to);
		clock_us = clock_us + step;
		send_tick(clock_us, rd, to);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		while (poll_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic reg_queue(input int unsigned idx, input logic [DATA_W-1:0] val);
		reg_idx_q.push_back(idx);
		reg_val_q.push_back(val);
	endtask

	// apb writes back to back, setup then access phase each
	task automatic reg_commit();
		while (reg_idx_q.size() != 0) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= ADDR_W'(reg_idx_q[0] << 2);
			pwdata  <= reg_val_q[0];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			cfg_apply(reg_idx_q.pop_front(), reg_val_q.pop_front());
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic random_config(input int kind);
		logic [DIST_W-1:0] thr;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			case (kind)
				0: thr = '0;
				1: thr = '1;
				default: begin
					case ($urandom_range(3))
						0: thr = '0;
						1: thr = '1;
						default: thr = DIST_W'($urandom);
					endcase
				end
			endcase
			reg_queue(REG_THR_RIGHT + i, DATA_W'(thr));
		end
		case (kind)
			0: begin
				reg_queue(REG_DETECT_EN, 32'd7);
				reg_queue(REG_BELOW, 32'd0);
				reg_queue(REG_DEPTH_EN, 32'd0);
			end
			1: begin
				reg_queue(REG_DETECT_EN, 32'd7);
				reg_queue(REG_BELOW, 32'd7);
				reg_queue(REG_DEPTH_EN, 32'd1);
			end
			default: begin
				reg_queue(REG_DETECT_EN, $urandom_range(7));
				reg_queue(REG_BELOW, $urandom_range(7));
				reg_queue(REG_DEPTH_EN, $urandom_range(1));
			end
		endcase
		reg_commit();
	endtask

	// mostly rising time with random steps, some due-boundary hits, some stray times
	task automatic run_traffic(input int unsigned target);
		int unsigned       goal;
		int unsigned       pick;
		logic [IDX_W-1:0]  cur;
		logic [TIME_W-1:0] t;
		logic [DIST_W-1:0] rd;
		goal = sent_count + target;
		while (sent_count < goal) begin
			pick = $urandom_range(99);
			cur  = (rr_turn > SENSOR_DEPTH) ? SENSOR_RIGHT : rr_turn;
			if (pick < 12) begin
				t = $urandom_range(32'hEFFF_FFFF);
				if (t > clock_us)
					clock_us = t;
			end else if (pick < 24 && sensor_due[cur] >= clock_us
					&& sensor_due[cur] < 32'hFFFF_0000) begin
				clock_us = sensor_due[cur] + $urandom_range(1);
				t = clock_us;
			end else begin
				clock_us = clock_us + ((pick < 40) ? $urandom_range(100) : $urandom_range(25000));
				t = clock_us;
			end
			case ($urandom_range(3))
				0, 1: rd = DIST_W'($urandom);
				2: rd = thr_mm[cur] + DIST_W'($urandom_range(2)) - 1'b1;
				default: rd = $urandom_range(1) ? '1 : '0;
			endcase
			send_tick(t, rd, $urandom_range(99) < 20);
		end
	endtask

	// due compare is strict, ticks before or at due time leave the state alone
	task automatic test_due_boundaries();
		send_tick(32'd0, 16'hFFFF, 1'b1);
		send_tick(32'd40000, 16'h0000, 1'b0);
		send_tick(32'd40001, 16'hFFFF, 1'b0);
		send_tick(32'd45001, 16'h1234, 1'b0);
		send_tick(32'd45002, 16'h0000, 1'b1);
		clock_us = 32'd50003;
		send_tick(clock_us, 16'h0000, 1'b0);
	endtask

	// readings equal to the threshold never hit, in either direction
	task automatic test_threshold_edges();
		drain();
		reg_queue(REG_THR_RIGHT, 32'd1000);
		reg_queue(REG_THR_LEFT, 32'd0);
		reg_queue(REG_THR_DEPTH, 32'h0000_FFFF);
		reg_queue(REG_DETECT_EN, 32'd7);
		reg_queue(REG_BELOW, 32'd3);
		reg_queue(REG_SPARE_A, 32'hFFFF_FFFF);
		reg_queue(REG_SPARE_B, 32'hFFFF_FFFF);
		reg_commit();
		poll_later(32'd50000, 16'd1000, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
		poll_later(32'd50000, 16'hFFFF, 1'b0);
		// wrong direction misses, and a disabled sensor stores without alarming
		drain();
		reg_queue(REG_THR_LEFT, 32'h0000_8000);
		reg_queue(REG_THR_DEPTH, 32'd1);
		reg_queue(REG_DETECT_EN, 32'd3);
		reg_queue(REG_BELOW, 32'd1);
		reg_commit();
		poll_later(32'd50000, 16'hFFFF, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
		poll_later(32'd50000, 16'hFFFF, 1'b0);
	endtask

	// first hit latches the stop once, a timeout does no alarm test
	task automatic test_alarm_and_stop();
		poll_later(32'd50000, 16'd999, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b1);
		poll_later(32'd50000, 16'd5, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
	endtask

	// rotation without the depth sensor, and depth turned off while it is in turn
	task automatic test_depth_skip();
		drain();
		reg_queue(REG_DEPTH_EN, 32'd0);
		reg_queue(REG_DETECT_EN, 32'd6);
		reg_queue(REG_BELOW, 32'd4);
		reg_queue(REG_THR_LEFT, 32'h0000_7FFF);
		reg_queue(REG_THR_DEPTH, 32'h0000_0010);
		reg_commit();
		poll_later(32'd50000, 16'h8000, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
		drain();
		reg_queue(REG_DEPTH_EN, 32'd1);
		reg_commit();
		poll_later(32'd50000, 16'd0, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
		drain();
		reg_queue(REG_DEPTH_EN, 32'd0);
		reg_commit();
		poll_later(32'd50000, 16'd0, 1'b0);
		poll_later(32'd50000, 16'd0, 1'b0);
	endtask

	// the top of the time range, reschedule wraps around
	task automatic test_time_wrap();
		send_tick(32'hFFFF_FFFF, 16'hA5A5, 1'b0);
		send_tick(32'h0000_0000, 16'h5A5A, 1'b0);
	endtask

	task automatic test_random_traffic();
		for (int seg = 0; seg < 5; seg++) begin
			drain();
			random_config(seg);
			// one long stretch with no idling on either side
			in_gaps  = (seg != 2);
			out_gaps = (seg != 2);
			run_traffic(260);
		end
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_output_backpressure();
		drain();
		random_config(2);
		in_gaps   = 1'b0;
		out_gaps  = 1'b1;
		hold_left = 400;
		run_traffic(150);
		in_gaps = 1'b1;
	endtask

	initial begin
		predictor_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_due_boundaries();
		test_threshold_edges();
		test_alarm_and_stop();
		test_depth_skip();
		test_time_wrap();
		test_random_traffic();
		test_output_backpressure();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (poll_expect_q.size() != 0)
			report_mismatch("missing results", 0, poll_expect_q.size());
		if (mismatches == 0) begin
			$display("[rangefinder_poll_obstacle_alarm_top] OK");
		end else begin
			$display("[rangefinder_poll_obstacle_alarm_top] ERROR");
		end
		$finish;
	end

endmodule
